FILE: design/nctd_pkg.sv
// Package for the NMEA coordinate to decimal degrees converter.
// Holds the payload structs, character and status codes, widths and the
// power-of-ten table. No dependencies.
package nctd_pkg;

    localparam int MAX_FRAC_DIGITS = 9;
    localparam int OUT_FRAC_BITS   = 24;

    localparam int OUT_W     = 34;
    localparam int DEG_W     = 32;
    localparam int DEG_CAP_W = 10;                 // degree value is capped at 1023
    localparam int FRAC_W    = 40;
    localparam int SCALE_W   = 30;                 // holds 10^9
    localparam int DEN_W     = 36;                 // holds 60 * 10^9
    localparam int PROD_W    = DEN_W + DEG_CAP_W;
    localparam int MAG_W     = 48;                 // |deg*den + minutes|
    localparam int QINT_W    = 11;                 // integer degrees stay below 2^11
    localparam int QUOT_W    = QINT_W + OUT_FRAC_BITS;
    localparam int REM_W     = DEN_W + 1;

    localparam logic [DEG_W-1:0] DEG_CAP = DEG_W'((1 << DEG_CAP_W) - 1);
    localparam logic [OUT_W-2:0] MAG_LIMIT = '1;   // 2^33 - 1

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_S       = 8'h53;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;
    localparam logic [1:0] ST_BAD_HEMI  = 2'd3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
        logic [7:0] hemisphere;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] degrees_q24;
        logic [1:0]              status;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [SCALE_W-1:0] pow10(input logic [3:0] n);
        logic [SCALE_W-1:0] v;
        unique case (n)
            4'd0:    v = SCALE_W'(1);
            4'd1:    v = SCALE_W'(10);
            4'd2:    v = SCALE_W'(100);
            4'd3:    v = SCALE_W'(1000);
            4'd4:    v = SCALE_W'(10000);
            4'd5:    v = SCALE_W'(100000);
            4'd6:    v = SCALE_W'(1000000);
            4'd7:    v = SCALE_W'(10000000);
            4'd8:    v = SCALE_W'(100000000);
            4'd9:    v = SCALE_W'(1000000000);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/nctd_div.sv
// Restoring divider, one quotient bit per cycle: floor(mag * 2^OUT_FRAC_BITS / den).
// Depends on nctd_pkg. The integer part of the quotient is known to fit QINT_W bits.
module nctd_div
    import nctd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_mag,
    input  logic [DEN_W-1:0]  i_den,
    output t_div_stat         o_stat,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_low;   // dividend bits in, quotient bits out
    logic [DEN_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  diff;
    logic              q_bit;

    always_comb begin
        trial = {r_rem[REM_W-2:0], r_low[QUOT_W-1]};
        diff  = trial - {1'b0, r_den};
        q_bit = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= REM_W'(i_mag >> QINT_W);
            r_low <= {i_mag[QINT_W-1:0], {OUT_FRAC_BITS{1'b0}}};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff : trial;
            r_low <= {r_low[QUOT_W-2:0], q_bit};
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_low;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0 && r_cnt <= CNT_W'(QUOT_W)))
        else $error("divider step count out of range");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !$past(i_start)) |-> (r_rem < {1'b0, r_den}))
        else $error("partial remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running division");

endmodule

FILE: design/nmea_coordinate_to_degrees_core.sv
// NMEA ddmm.mmmm coordinate field to signed decimal degrees, Q.24, one byte per
// transaction. Every byte but the last is taken without a stall. The last byte
// starts the conversion: a malformed field or unknown hemisphere goes from
// S_FINISH straight to S_DONE; a normal field passes S_MUL_MIN and S_MUL_TOT
// on the shared 36x10 multiplier (two passes), then S_DIV on the bit-serial
// divider (35 steps, one quotient bit a cycle). o_stall stays high until the
// result is loaded; it then waits in the output register while further bytes
// are taken. Depends on nctd_pkg and nctd_div.
module nmea_coordinate_to_degrees_core
    import nctd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_FINISH  = 6'b000010,
        S_MUL_MIN = 6'b000100,
        S_MUL_TOT = 6'b001000,
        S_DIV     = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state r_state;

    // field parse state
    logic [DEG_W-1:0]        r_deg_acc;
    logic                    r_deg_bad;
    logic [3:0]              r_rdig [2];
    logic                    r_rbad [2];
    logic [4:0]              r_int_cnt;
    logic                    r_dot;
    logic signed [FRAC_W-1:0] r_frac_acc;
    logic [3:0]              r_frac_cnt;
    logic [7:0]              r_hemi;

    // conversion datapath
    logic [DEN_W-1:0]        r_den;
    logic signed [MAG_W-1:0] r_mins;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic                    r_div_go;
    logic [1:0]              r_res_status;
    logic [QUOT_W-1:0]       r_quot;

    logic                    r_out_valid;
    t_out_item               r_out;

    // byte parsing
    logic                    in_acc;
    logic [7:0]              b;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [DEG_W+3:0]        deg_x10;
    logic signed [8:0]       b_sgn;
    logic signed [FRAC_W-1:0] frac_next;

    // finishing
    logic                    malformed;
    logic                    hemi_known;
    logic                    hemi_neg;
    logic [SCALE_W-1:0]      scale;
    logic [DEN_W-1:0]        den_c;
    logic [6:0]              minutes_int;
    logic [DEG_CAP_W-1:0]    deg_c;
    logic [DEN_W-1:0]        mul_a;
    logic [DEG_CAP_W-1:0]    mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic signed [MAG_W-1:0] total;
    logic                    sat;
    logic [OUT_W-2:0]        mag_fin;
    logic                    load;

    t_div_stat               div_stat;
    logic [QUOT_W-1:0]       div_quot;

    always_comb begin
        in_acc    = i_valid && !o_stall;
        b         = i_data.char_byte;
        is_digit  = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
        digit     = is_digit ? 4'(b - ASCII_ZERO) : 4'd0;
        deg_x10   = ({4'b0, r_deg_acc} << 3) + ({4'b0, r_deg_acc} << 1)
                  + (DEG_W+4)'(r_rdig[1]);
        b_sgn     = $signed({1'b0, b}) - 9'sd48;
        frac_next = (r_frac_acc <<< 3) + (r_frac_acc <<< 1) + FRAC_W'(b_sgn);
    end

    always_comb begin
        malformed  = !r_dot || (r_int_cnt < 5'd2);
        hemi_known = (r_hemi == CH_N) || (r_hemi == CH_E)
                  || (r_hemi == CH_W) || (r_hemi == CH_S);
        hemi_neg   = (r_hemi == CH_W) || (r_hemi == CH_S);
        scale      = pow10(r_frac_cnt);
        den_c      = ({6'b0, scale} << 6) - ({6'b0, scale} << 2);   // 60 * scale
        minutes_int = ({3'b0, r_rdig[1]} << 3) + ({3'b0, r_rdig[1]} << 1)
                    + {3'b0, r_rdig[0]};
        deg_c      = r_deg_bad ? '0 :
                     (r_deg_acc > DEG_CAP) ? DEG_CAP[DEG_CAP_W-1:0]
                                           : r_deg_acc[DEG_CAP_W-1:0];
        // one multiplier: minutes * scale first, then degrees * den
        if (r_state == S_MUL_MIN) begin
            mul_a = DEN_W'(scale);
            mul_b = DEG_CAP_W'(minutes_int);
        end else begin
            mul_a = r_den;
            mul_b = deg_c;
        end
        mul_p   = mul_a * mul_b;
        total   = $signed({2'b0, mul_p}) + r_mins;
        sat     = r_quot > QUOT_W'(MAG_LIMIT);
        mag_fin = sat ? MAG_LIMIT : r_quot[OUT_W-2:0];
        load    = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_deg_acc   <= '0;
            r_deg_bad   <= 1'b0;
            r_rdig[0]   <= '0;
            r_rdig[1]   <= '0;
            r_rbad[0]   <= 1'b0;
            r_rbad[1]   <= 1'b0;
            r_int_cnt   <= '0;
            r_dot       <= 1'b0;
            r_frac_acc  <= '0;
            r_frac_cnt  <= '0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go    <= (r_state == S_MUL_TOT);
            r_out_valid <= load || (r_out_valid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!r_dot) begin
                            if (b == CH_DOT) begin
                                r_dot <= 1'b1;
                            end else begin
                                if (r_int_cnt >= 5'd2) begin
                                    if (r_rbad[1]) begin
                                        r_deg_bad <= 1'b1;
                                    end else begin
                                        r_deg_acc <= (deg_x10[DEG_W+3:DEG_W] != '0) ?
                                                     '1 : deg_x10[DEG_W-1:0];
                                    end
                                end
                                r_rdig[1] <= r_rdig[0];
                                r_rbad[1] <= r_rbad[0];
                                r_rdig[0] <= digit;
                                r_rbad[0] <= !is_digit;
                                if (r_int_cnt != 5'd31) begin
                                    r_int_cnt <= r_int_cnt + 1'b1;
                                end
                            end
                        end else if (r_frac_cnt < 4'(MAX_FRAC_DIGITS)) begin
                            r_frac_acc <= frac_next;
                            r_frac_cnt <= r_frac_cnt + 1'b1;
                        end
                        if (i_data.last_byte) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (malformed || !hemi_known) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL_MIN;
                    end
                end
                S_MUL_MIN: begin
                    r_state <= S_MUL_TOT;
                end
                S_MUL_TOT: begin
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_state     <= S_IDLE;
                        r_deg_acc   <= '0;
                        r_deg_bad   <= 1'b0;
                        r_rdig[0]   <= '0;
                        r_rdig[1]   <= '0;
                        r_rbad[0]   <= 1'b0;
                        r_rbad[1]   <= 1'b0;
                        r_int_cnt   <= '0;
                        r_dot       <= 1'b0;
                        r_frac_acc  <= '0;
                        r_frac_cnt  <= '0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc && i_data.last_byte) begin
            r_hemi <= i_data.hemisphere;
        end
        if (r_state == S_FINISH) begin
            r_res_status <= malformed ? ST_MALFORMED :
                            (!hemi_known ? ST_BAD_HEMI : ST_OK);
            r_quot <= '0;
            r_neg  <= 1'b0;
        end
        if (r_state == S_MUL_MIN) begin
            r_den  <= den_c;
            // a bad minute digit zeroes the whole minutes, fraction included
            r_mins <= (r_rbad[0] || r_rbad[1]) ? '0 :
                      ($signed({2'b0, mul_p}) + MAG_W'(r_frac_acc));
        end
        if (r_state == S_MUL_TOT) begin
            r_neg <= total[MAG_W-1];
            r_mag <= total[MAG_W-1] ? MAG_W'(-total) : MAG_W'(total);
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_quot <= div_quot;
        end
        if (load) begin
            r_out.degrees_q24 <= (r_neg ^ hemi_neg) ? -$signed({1'b0, mag_fin})
                                                    :  $signed({1'b0, mag_fin});
            r_out.status      <= sat ? ST_SATURATED : r_res_status;
        end
    end

    nctd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_mag   (r_mag),
        .i_den   (r_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_clear_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_int_cnt == '0 && !r_dot && r_frac_cnt == '0 && !r_deg_bad))
        else $error("field state not cleared after a result");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac_cnt <= 4'(MAX_FRAC_DIGITS))
        else $error("fraction digit count past the limit");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=> (r_state == S_DONE))
        else $error("result produced over a pending transaction");

    a_div_idle_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while taking bytes");

endmodule

FILE: sim/tb_nmea_coordinate_to_degrees_core.sv
// Testbench for nmea_coordinate_to_degrees_core: streams coordinate fields byte by byte
// and checks every degrees/status result against an in-bench predictor.
// Depends on nctd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_nmea_coordinate_to_degrees_core;
    import nctd_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 100;
    localparam int RANDOM_BYTES = 1200;

    typedef struct {
        t_in_item item;
        bit       drain;       // wait for all results before sending this byte
    } t_field_byte;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_data  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;
    logic      i_stall = 1'b0;

    t_field_byte field_bytes_q[$];
    logic [7:0]  field_buf[$];
    t_out_item   pending_degrees[$];

    int  outstanding  = 0;
    int  sent_count   = 0;
    int  errors       = 0;
    int  quiet_cycles = 0;
    bit  draining     = 1'b0;
    logic calm;
    logic stuck;

    // predictor state for the field in progress
    logic [31:0] deg_acc    = '0;
    bit          deg_bad    = 1'b0;
    logic [3:0]  min_digit[2] = '{4'd0, 4'd0};
    bit          min_bad[2]   = '{1'b0, 1'b0};
    logic [4:0]  int_len    = '0;
    bit          dot_found  = 1'b0;
    longint      frac_acc   = 0;
    logic [3:0]  frac_len   = '0;

    t_out_item predicted;
    t_out_item want;

    nmea_coordinate_to_degrees_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    assign calm  = (sent_count >= 400) && (sent_count < 700);
    assign stuck = (quiet_cycles >= QUIET_LIMIT);

    // Advances the field parser by one byte; returns 1 when the byte closes a field.
    function automatic bit convert_nmea_byte(input t_in_item it, output t_out_item res);
        logic [63:0]     grown;
        longint unsigned scale;
        longint unsigned den;
        longint unsigned deg_val;
        longint unsigned mag;
        longint          minutes;
        longint          total;
        longint          signed_val;
        bit              neg;
        bit              is_digit;
        logic [1:0]      st;
        res = '0;
        if (!dot_found) begin
            if (it.char_byte == CH_DOT) begin
                dot_found = 1'b1;
            end else begin
                is_digit = (it.char_byte >= ASCII_ZERO) && (it.char_byte <= ASCII_NINE);
                // the older pending digit moves into the degree part
                if (int_len >= 2) begin
                    if (min_bad[1]) begin
                        deg_bad = 1'b1;
                    end else begin
                        grown = {32'd0, deg_acc} * 64'd10 + min_digit[1];
                        deg_acc = (grown > 64'hFFFF_FFFF) ? '1 : grown[31:0];
                    end
                end
                min_digit[1] = min_digit[0];
                min_bad[1]   = min_bad[0];
                min_digit[0] = is_digit ? 4'(it.char_byte - ASCII_ZERO) : 4'd0;
                min_bad[0]   = !is_digit;
                if (int_len < 31) int_len++;
            end
        end else if (frac_len < MAX_FRAC_DIGITS) begin
            frac_acc = frac_acc * 10 + (longint'(it.char_byte) - longint'(ASCII_ZERO));
            frac_len++;
        end

        if (!it.last_byte) return 1'b0;

        signed_val = 0;
        st = ST_OK;
        if (!dot_found || int_len < 2) begin
            st = ST_MALFORMED;
        end else if (it.hemisphere != CH_N && it.hemisphere != CH_E &&
                     it.hemisphere != CH_W && it.hemisphere != CH_S) begin
            st = ST_BAD_HEMI;
        end else begin
            scale = 1;
            repeat (frac_len) scale = scale * 10;
            den = 60 * scale;
            deg_val = deg_bad ? 0 : ((deg_acc > 32'd1023) ? 1023 : deg_acc);
            minutes = 0;
            if (!min_bad[0] && !min_bad[1])
                minutes = longint'(min_digit[1] * 10 + min_digit[0]) * longint'(scale)
                          + frac_acc;
            total = longint'(deg_val * den) + minutes;
            neg = (total < 0);
            mag = neg ? longint'(-total) : longint'(total);
            mag = ((mag / den) << OUT_FRAC_BITS) + (((mag % den) << OUT_FRAC_BITS) / den);
            if (mag > MAG_LIMIT) begin
                mag = MAG_LIMIT;
                st = ST_SATURATED;
            end
            if (it.hemisphere == CH_W || it.hemisphere == CH_S) neg = !neg;
            signed_val = neg ? -longint'(mag) : longint'(mag);
        end
        res.degrees_q24 = OUT_W'(signed_val);
        res.status = st;

        deg_acc   = '0;
        deg_bad   = 1'b0;
        min_digit = '{4'd0, 4'd0};
        min_bad   = '{1'b0, 1'b0};
        int_len   = '0;
        dot_found = 1'b0;
        frac_acc  = 0;
        frac_len  = '0;
        return 1'b1;
    endfunction

    task automatic append_text(input string s);
        for (int k = 0; k < s.len(); k++) field_buf.push_back(s[k]);
    endtask

    // Moves the buffered field into the send queue; hemisphere matters on the last byte only.
    task automatic emit_field(input logic [7:0] hemi, input bit drain);
        t_field_byte fb;
        for (int k = 0; k < field_buf.size(); k++) begin
            fb.item.char_byte  = field_buf[k];
            fb.item.last_byte  = (k == field_buf.size() - 1);
            fb.item.hemisphere = fb.item.last_byte ? hemi : 8'($urandom_range(0, 255));
            fb.drain = drain && (k == 0);
            field_bytes_q.push_back(fb);
        end
        field_buf.delete();
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(ASCII_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic random_field(input bit drain);
        int kind;
        int n_deg;
        int n_frac;
        logic [7:0] hemi;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            // fewer than two bytes ahead of the dot
            repeat ($urandom_range(0, 1)) field_buf.push_back(rand_digit());
            field_buf.push_back(CH_DOT);
            repeat ($urandom_range(0, 4)) field_buf.push_back(rand_digit());
        end else begin
            if (kind < 10)      n_deg = $urandom_range(28, 34);
            else if (kind < 20) n_deg = $urandom_range(4, 12);
            else                n_deg = $urandom_range(0, 3);
            repeat (n_deg) field_buf.push_back(rand_digit());
            field_buf.push_back(rand_digit());
            field_buf.push_back(rand_digit());
            if (kind >= 14) begin
                field_buf.push_back(CH_DOT);
                n_frac = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13)
                                                     : $urandom_range(0, 9);
                repeat (n_frac) field_buf.push_back(rand_digit());
            end
        end
        if ($urandom_range(0, 99) < 12)
            field_buf[$urandom_range(0, field_buf.size() - 1)] = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:     hemi = CH_N;
            5, 6, 7, 8:        hemi = CH_E;
            9, 10, 11, 12:     hemi = CH_W;
            13, 14, 15, 16:    hemi = CH_S;
            default:           hemi = 8'($urandom_range(0, 255));
        endcase
        emit_field(hemi, drain);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            draining <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (field_bytes_q.size() == 0 || (!calm && $urandom_range(0, 99) < 28)) begin
                i_valid <= 1'b0;
            end else if (field_bytes_q[0].drain && !draining) begin
                i_valid  <= 1'b0;
                draining <= 1'b1;
            end else if (draining && outstanding != 0) begin
                i_valid <= 1'b0;
            end else begin
                i_valid    <= 1'b1;
                i_data     <= field_bytes_q[0].item;
                void'(field_bytes_q.pop_front());
                draining   <= 1'b0;
                sent_count <= sent_count + 1;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else          i_stall <= !calm && ($urandom_range(0, 99) < 28);
    end

    // monitor: predicts on accepted bytes, checks accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (convert_nmea_byte(i_data, predicted)) pending_degrees.push_back(predicted);
            end
            if (o_valid && !i_stall) begin
                if (pending_degrees.size() == 0) begin
                    $display("%0t: unexpected transaction, actual degrees %0d status %0d",
                             $time, o_data.degrees_q24, o_data.status);
                    errors++;
                end else begin
                    want = pending_degrees.pop_front();
                    if (o_data.degrees_q24 !== want.degrees_q24) begin
                        $display("%0t: degrees_q24 expected %0d actual %0d",
                                 $time, want.degrees_q24, o_data.degrees_q24);
                        errors++;
                    end
                    if (o_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_data.status);
                        errors++;
                    end
                end
            end
            outstanding <= pending_degrees.size();
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        // directed fields
        append_text(".");                                   // dot with no integer bytes
        emit_field(CH_N, 1'b0);
        field_buf.push_back(8'hFF);                         // no dot at all
        emit_field(CH_E, 1'b0);
        append_text("12.");                                 // unknown hemisphere
        emit_field(8'h00, 1'b0);
        append_text("99.9");
        emit_field(CH_S, 1'b0);
        append_text("99999.");                              // degrees far past the range
        emit_field(CH_W, 1'b0);
        field_buf.push_back(8'h00);                         // non-digit degree byte
        append_text("12.5");
        emit_field(CH_E, 1'b0);
        append_text("7:1.5");                               // non-digit minute byte
        emit_field(CH_N, 1'b0);
        // negative fraction, repeated dots, more fraction bytes than kept
        append_text("00.");
        field_buf.push_back(8'h00);
        repeat (9) field_buf.push_back(CH_DOT);
        emit_field(CH_N, 1'b1);

        while (field_bytes_q.size() < RANDOM_BYTES)
            random_field($urandom_range(0, 29) == 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((field_bytes_q.size() != 0 || i_valid || outstanding != 0) && !stuck)
            @(posedge i_clk);
        if (!stuck) repeat (TAIL_CYCLES) @(posedge i_clk);

        if (stuck)
            $display("RESULT: ERROR");
        else if (errors == 0 && pending_degrees.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: nmea_coordinate_to_degrees_core.f
design/nctd_pkg.sv
design/nctd_div.sv
design/nmea_coordinate_to_degrees_core.sv
sim/tb_nmea_coordinate_to_degrees_core.sv
